FILE: hdl/sdbs_pkg.sv
package sdbs_pkg;

    localparam int MAX_PIXELS_DEF = 131072;

    localparam int IDX_W  = 17;
    localparam int PIX_W  = 8;
    localparam int GAIN_W = 4;
    localparam int SPR_W  = 8;
    localparam int CFG_W  = 8;

    // gain * difference
    localparam int TGT_W  = GAIN_W + PIX_W;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_INIT   = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RST       = 4'd2;
    localparam logic [SPR_W-1:0]  SPREAD_MIN_RST = 8'd1;
    localparam logic [SPR_W-1:0]  SPREAD_MAX_RST = 8'd254;

    typedef enum logic [1:0] {
        CFG_GAIN       = 2'd0,
        CFG_SPREAD_MIN = 2'd1,
        CFG_SPREAD_MAX = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] pixel_index;
        logic [PIX_W-1:0] pixel_value;
    } t_in;

    typedef struct packed {
        logic             motion;
        logic [PIX_W-1:0] abs_difference;
        logic [PIX_W-1:0] background;
        logic [SPR_W-1:0] spread;
    } t_out;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [SPR_W-1:0]  spread_min;
        logic [SPR_W-1:0]  spread_max;
    } t_cfg;

    // one stored entry: background and spread side by side
    typedef struct packed {
        logic [PIX_W-1:0] bg;
        logic [SPR_W-1:0] sp;
    } t_entry;

endpackage

FILE: hdl/sigma_delta_background_subtract.sv
// Sigma-delta background subtraction, one grey pixel per transaction. Each pixel
// position keeps an 8-bit background and an 8-bit spread in a single on-chip
// memory of MAX_PIXELS 16-bit words (one read port, one write port, registered
// read). An initialise transaction loads the entry with the pixel and spread_min;
// an update transaction reads the entry, steps the background and the spread one
// level each, clamps the spread and flags motion when the difference reaches the
// spread. Throughput is one transaction per clock unless the output stalls;
// the memory read and the stage 1 registers are loaded at acceptance, and the
// update, the write-back and the output load happen together when stage 1
// retires into the output register. Back-to-back transactions to the same
// pixel are handled by forwarding the previous write, so there is no stall on
// address collisions. The memory has no reset and no clearing pass: every pixel
// must be initialised before it is updated. A pixel_index at or beyond
// MAX_PIXELS leaves the memory untouched and returns a result of all zeros.
// Configuration registers may only be written while no transaction is in flight.
module sigma_delta_background_subtract
    import sdbs_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,

    // configuration
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,

    // pixel in
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in              i_data,

    // result out
    output logic             o_valid,
    input  logic             i_stall,
    output t_out             o_data
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain       <= GAIN_RST;
            r_cfg.spread_min <= SPREAD_MIN_RST;
            r_cfg.spread_max <= SPREAD_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN:       r_cfg.gain       <= i_cfg_data[GAIN_W-1:0];
                CFG_SPREAD_MIN: r_cfg.spread_min <= i_cfg_data[SPR_W-1:0];
                CFG_SPREAD_MAX: r_cfg.spread_max <= i_cfg_data[SPR_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 0: accept, decode index, issue memory read
    // ------------------------------------------------------------------
    logic          in_acc;
    logic          s1_adv;
    logic [XW-1:0] in_idx_x;
    logic [AW-1:0] in_addr;
    logic          in_range;

    assign in_acc   = i_valid && !o_stall;
    assign in_idx_x = XW'(i_data.pixel_index);
    assign in_addr  = in_idx_x[AW-1:0];
    assign in_range = (32'(i_data.pixel_index) < 32'(MAX_PIXELS));

    // stage 1 registers
    logic             r_s1_valid;
    logic             r_s1_req;
    logic             r_s1_range;
    logic [AW-1:0]    r_s1_addr;
    logic [PIX_W-1:0] r_s1_pix;

    // stage 1 holds while the output register is full and stalled
    assign o_stall = r_s1_valid && !s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_req   <= i_data.req_type;
            r_s1_range <= in_range;
            r_s1_addr  <= in_addr;
            r_s1_pix   <= i_data.pixel_value;
        end
    end

    // ------------------------------------------------------------------
    // entry memory: read at accept, write back when stage 1 retires
    // ------------------------------------------------------------------
    t_entry r_store [MAX_PIXELS];
    t_entry r_rd;
    logic   wr_en;
    t_entry wr_data;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd <= r_store[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_s1_addr] <= wr_data;
        end
    end

    // The read issued at an accept edge misses a write made at that same edge;
    // remember that write and forward it to the new stage 1 item.
    logic          r_wr_valid;
    logic [AW-1:0] r_wr_addr;
    t_entry        r_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
        end else if (in_acc) begin
            r_wr_valid <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_wr_addr <= r_s1_addr;
            r_wr_data <= wr_data;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: read-modify-write
    // ------------------------------------------------------------------
    t_entry           cur;
    t_entry           upd;
    logic [PIX_W-1:0] upd_diff;
    logic             upd_motion;
    t_out             s1_res;

    assign cur = (r_wr_valid && (r_wr_addr == r_s1_addr)) ? r_wr_data : r_rd;

    sdbs_update u_update (
        .i_cfg    (r_cfg),
        .i_pixel  (r_s1_pix),
        .i_entry  (cur),
        .o_entry  (upd),
        .o_diff   (upd_diff),
        .o_motion (upd_motion)
    );

    always_comb begin
        s1_res     = '0;
        wr_data.bg = r_s1_pix;
        wr_data.sp = r_cfg.spread_min;
        if (r_s1_range) begin
            if (r_s1_req == REQ_INIT) begin
                s1_res.background = r_s1_pix;
                s1_res.spread     = r_cfg.spread_min;
            end else begin
                wr_data               = upd;
                s1_res.motion         = upd_motion;
                s1_res.abs_difference = upd_diff;
                s1_res.background     = upd.bg;
                s1_res.spread         = upd.sp;
            end
        end
    end

    assign wr_en = r_s1_valid && s1_adv && r_s1_range;

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic r_out_valid;
    t_out r_out;

    assign s1_adv = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out <= s1_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    // a held stage 1 item is never dropped
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid)
        else $error("stage 1 item lost while held");

    // memory written only by a retiring in-range item
    a_wr_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_s1_valid && r_s1_range))
        else $error("memory write without a retiring item");

    // forwarding only refers to a write made at the accepting edge
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && wr_en) |=> (r_wr_valid && (r_wr_addr == $past(r_s1_addr))))
        else $error("forwarded write not captured");

    // motion flag agrees with the reported difference and spread
    a_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.motion) |-> (o_data.abs_difference >= o_data.spread))
        else $error("motion set with difference below spread");
`endif

endmodule

FILE: hdl/sdbs_update.sv
module sdbs_update
    import sdbs_pkg::*;
(
    input  t_cfg             i_cfg,
    input  logic [PIX_W-1:0] i_pixel,
    input  t_entry           i_entry,
    output t_entry           o_entry,
    output logic [PIX_W-1:0] o_diff,
    output logic             o_motion
);

    logic [PIX_W-1:0] bg_n;
    logic [PIX_W-1:0] diff;
    logic [TGT_W-1:0] target;
    logic [SPR_W:0]   sp_step;
    logic [SPR_W:0]   sp_hi;
    logic [SPR_W-1:0] sp_n;

    always_comb begin
        // background steps one grey level toward the pixel
        priority if (i_entry.bg < i_pixel) begin
            bg_n = i_entry.bg + PIX_W'(1);
        end else if (i_entry.bg > i_pixel) begin
            bg_n = i_entry.bg - PIX_W'(1);
        end else begin
            bg_n = i_entry.bg;
        end

        diff   = (bg_n > i_pixel) ? (bg_n - i_pixel) : (i_pixel - bg_n);
        target = TGT_W'(i_cfg.gain) * TGT_W'(diff);

        // step one wider than the store so 255 + 1 does not wrap
        priority if (TGT_W'(i_entry.sp) < target) begin
            sp_step = (SPR_W+1)'(i_entry.sp) + (SPR_W+1)'(1);
        end else if (TGT_W'(i_entry.sp) > target) begin
            sp_step = (SPR_W+1)'(i_entry.sp) - (SPR_W+1)'(1);
        end else begin
            sp_step = (SPR_W+1)'(i_entry.sp);
        end

        // upper clamp first, lower clamp wins
        sp_hi = (sp_step > (SPR_W+1)'(i_cfg.spread_max)) ?
                (SPR_W+1)'(i_cfg.spread_max) : sp_step;
        sp_n  = (sp_hi < (SPR_W+1)'(i_cfg.spread_min)) ?
                i_cfg.spread_min : sp_hi[SPR_W-1:0];
    end

    assign o_entry.bg = bg_n;
    assign o_entry.sp = sp_n;
    assign o_diff     = diff;
    assign o_motion   = (diff >= sp_n);

endmodule
